// ----- sv/iparc_pkg.sv -----
`default_nettype none

package iparc_pkg;

    localparam int HEADER_BYTES = 20;
    localparam int CSUM_FIRST   = 10;
    localparam int SRC_FIRST    = 12;
    localparam int DST_FIRST    = 16;
    localparam int IP_VERSION   = 4;

    // Bytes 10..19 leave together as one burst; bytes 10..18 wait in the hold bank.
    localparam int BURST_MAX  = HEADER_BYTES - CSUM_FIRST;
    localparam int HELD_COUNT = BURST_MAX - 1;
    localparam int HELD_IDX_W = $clog2(HELD_COUNT);
    localparam int BURST_CNT_W = $clog2(BURST_MAX + 1);

    localparam int POS_W = $clog2(HEADER_BYTES + 1);

    // The queue holds one full burst plus room for the bytes still draining.
    localparam int QUEUE_DEPTH = 16;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int ADDR_W = 32;

    // Configuration register indexes.
    localparam logic [1:0] REG_SRC_ADDR = 2'd0;
    localparam logic [1:0] REG_DST_ADDR = 2'd1;
    localparam logic [1:0] REG_SRC_EN   = 2'd2;
    localparam logic [1:0] REG_DST_EN   = 2'd3;

    typedef struct packed {
        logic       short_header;
        logic       not_version_four;
        logic       last;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [BURST_CNT_W-1:0]  cnt;
        item_t [BURST_MAX-1:0]   items;
    } burst_t;

endpackage

`default_nettype wire

// ----- sv/iparc_core.sv -----
`default_nettype none

module iparc_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [7:0]                         s_data,
    input  wire logic                               s_last,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [1:0]                         cfg_index,
    input  wire logic [iparc_pkg::ADDR_W-1:0]       cfg_data,
    input  wire logic [iparc_pkg::QUEUE_CNT_W-1:0]  queue_count,
    output iparc_pkg::burst_t                       burst
);
    import iparc_pkg::*;

    logic [ADDR_W-1:0]     src_addr_reg;
    logic [ADDR_W-1:0]     dst_addr_reg;
    logic                  src_en_reg;
    logic                  dst_en_reg;

    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [15:0]           sum_reg, sum_next;
    logic                  pass_reg, pass_next;
    logic [7:0]            held_reg [HELD_COUNT];

    logic                  accept;
    logic                  pass_now;
    logic [15:0]           sum_base;
    logic [16:0]           byte_sum;
    logic [HELD_IDX_W-1:0] hold_idx;
    logic [7:0]            hdr [BURST_MAX];
    logic [18:0]           word_total;
    logic [16:0]           fold_one;
    logic [15:0]           fold_two;
    logic [15:0]           csum;
    logic [POS_W-1:0]      need;
    logic [QUEUE_CNT_W-1:0] queue_free;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid & s_ready;

    // Room is checked against the largest burst the current position could cause.
    assign queue_free = QUEUE_CNT_W'(QUEUE_DEPTH) - queue_count;
    always_comb begin
        if (!pass_reg && pos_reg >= POS_W'(CSUM_FIRST) && pos_reg < POS_W'(HEADER_BYTES)) begin
            need = pos_reg - POS_W'(CSUM_FIRST - 1);
        end else begin
            need = POS_W'(1);
        end
    end
    assign s_ready = (QUEUE_CNT_W'(need) <= queue_free);

    assign pass_now = (pos_reg == '0) ? (s_data[7:4] != 4'(IP_VERSION)) : pass_reg;
    assign sum_base = (pos_reg == '0) ? 16'h0000 : sum_reg;
    assign byte_sum = 17'(sum_base) + (pos_reg[0] ? {9'h000, s_data} : {1'b0, s_data, 8'h00});
    assign hold_idx = HELD_IDX_W'(pos_reg - POS_W'(CSUM_FIRST));

    always_comb begin
        for (int i = 0; i < HELD_COUNT; i++) begin
            hdr[i] = held_reg[i];
        end
        hdr[HELD_COUNT] = s_data;
        for (int i = 0; i < 4; i++) begin
            if (src_en_reg) begin
                hdr[SRC_FIRST - CSUM_FIRST + i] = src_addr_reg[8*(3-i) +: 8];
            end
            if (dst_en_reg) begin
                hdr[DST_FIRST - CSUM_FIRST + i] = dst_addr_reg[8*(3-i) +: 8];
            end
        end
        // Four address words plus the sum of bytes 0..9, then two end-around folds.
        word_total = 19'(sum_reg) + 19'({hdr[2], hdr[3]}) + 19'({hdr[4], hdr[5]})
                   + 19'({hdr[6], hdr[7]}) + 19'({hdr[8], hdr[9]});
        fold_one = 17'(word_total[15:0]) + 17'(word_total[18:16]);
        fold_two = fold_one[15:0] + 16'(fold_one[16]);
        csum     = ~fold_two;
    end

    always_comb begin
        burst     = '0;
        pos_next  = pos_reg;
        sum_next  = sum_base;
        pass_next = pass_reg;
        if (accept) begin
            if (pos_reg == '0) begin
                pass_next = pass_now;
            end
            priority if (pass_now) begin
                burst.cnt            = BURST_CNT_W'(1);
                burst.items[0].data  = s_data;
                burst.items[0].last  = s_last;
                burst.items[0].not_version_four = 1'b1;
            end else if (pos_reg < POS_W'(CSUM_FIRST)) begin
                sum_next = byte_sum[15:0] + 16'(byte_sum[16]);
                burst.cnt            = BURST_CNT_W'(1);
                burst.items[0].data  = s_data;
                burst.items[0].last  = s_last;
                burst.items[0].short_header = s_last;
            end else if (pos_reg < POS_W'(HEADER_BYTES - 1)) begin
                // A packet that ends inside the hold window flushes its bytes unchanged.
                if (s_last) begin
                    burst.cnt = BURST_CNT_W'(pos_reg - POS_W'(CSUM_FIRST - 1));
                    for (int i = 0; i < HELD_COUNT; i++) begin
                        burst.items[i].data = (HELD_IDX_W'(i) == hold_idx) ? s_data
                                                                         : held_reg[i];
                        burst.items[i].last = (HELD_IDX_W'(i) == hold_idx);
                        burst.items[i].short_header = 1'b1;
                    end
                end
            end else if (pos_reg == POS_W'(HEADER_BYTES - 1)) begin
                burst.cnt = BURST_CNT_W'(BURST_MAX);
                for (int i = 0; i < BURST_MAX; i++) begin
                    burst.items[i].data = hdr[i];
                end
                burst.items[0].data = csum[15:8];
                burst.items[1].data = csum[7:0];
                burst.items[BURST_MAX-1].last = s_last;
            end else begin
                burst.cnt            = BURST_CNT_W'(1);
                burst.items[0].data  = s_data;
                burst.items[0].last  = s_last;
            end
            if (s_last) begin
                pos_next  = '0;
                sum_next  = 16'h0000;
                pass_next = 1'b0;
            end else if (pos_reg < POS_W'(HEADER_BYTES)) begin
                pos_next = pos_reg + POS_W'(1);
            end
        end else begin
            sum_next = sum_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            sum_reg      <= '0;
            pass_reg     <= 1'b0;
            src_addr_reg <= '0;
            dst_addr_reg <= '0;
            src_en_reg   <= 1'b0;
            dst_en_reg   <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            pass_reg <= pass_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_SRC_ADDR: src_addr_reg <= cfg_data;
                    REG_DST_ADDR: dst_addr_reg <= cfg_data;
                    REG_SRC_EN:   src_en_reg   <= cfg_data[0];
                    REG_DST_EN:   dst_en_reg   <= cfg_data[0];
                    default:      src_en_reg   <= src_en_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !pass_now && pos_reg >= POS_W'(CSUM_FIRST)
                && pos_reg < POS_W'(HEADER_BYTES - 1)) begin
            held_reg[hold_idx] <= s_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/iparc_queue.sv -----
`default_nettype none

module iparc_queue (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire iparc_pkg::burst_t                  burst,
    output logic [iparc_pkg::QUEUE_CNT_W-1:0]       count,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output iparc_pkg::item_t                        m_item
);
    import iparc_pkg::*;

    item_t                  q_reg  [QUEUE_DEPTH];
    item_t                  q_next [QUEUE_DEPTH];
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic [QUEUE_CNT_W-1:0] base;
    logic [QUEUE_CNT_W-1:0] ofs;
    logic                   pop;

    assign count   = count_reg;
    assign m_valid = (count_reg != '0);
    assign m_item  = q_reg[0];
    assign pop     = m_valid & m_ready;
    assign base    = count_reg - QUEUE_CNT_W'(pop);

    // Head always sits in entry 0; a pop shifts everything down and a burst
    // lands right behind whatever remains.
    always_comb begin
        ofs = '0;
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            if (pop && j < QUEUE_DEPTH - 1) begin
                q_next[j] = q_reg[j+1];
            end else begin
                q_next[j] = q_reg[j];
            end
            ofs = QUEUE_CNT_W'(j) - base;
            if (ofs < QUEUE_CNT_W'(burst.cnt)) begin
                q_next[j] = burst.items[ofs[QUEUE_IDX_W-1:0]];
            end
        end
        count_next = base + QUEUE_CNT_W'(burst.cnt);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            q_reg[j] <= q_next[j];
        end
    end

endmodule

`default_nettype wire

// ----- sv/ipv4_address_rewrite_checksum.sv -----
`default_nettype none

// Channel   Direction  Ports                                  Payload
// s_axis    in         s_axis_tvalid/tready/tdata/tlast       packet byte, last flag
// m_axis    out        m_axis_tvalid/tready/tdata/tlast/tuser byte, last, two flags
// cfg       in         cfg_valid/ready/index/data             register index, value
//
// One input byte is taken per cycle. Each byte is folded into the header state in
// the cycle it is accepted and its results enter a 16-entry output queue; header
// byte 19 (or a packet end inside bytes 10..18) loads up to ten results at once.
// The queue drains one result per cycle, so the stream runs at one byte per cycle
// while the output side keeps up; s_axis_tready drops only when the queue lacks
// room for the largest burst the next byte could cause.
// Reset is synchronous, active low, and clears the packet state, the queue and
// the configuration registers.
module ipv4_address_rewrite_checksum (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,   // [7:0] in_byte
    input  wire logic                          s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [7:0]                         m_axis_tdata,   // [7:0] out_byte
    output logic                               m_axis_tlast,
    output logic [1:0]                         m_axis_tuser,   // [0] not_version_four,
                                                               // [1] short_header
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [iparc_pkg::ADDR_W-1:0]  cfg_data
);
    import iparc_pkg::*;

    burst_t                 burst;
    item_t                  m_item;
    logic [QUEUE_CNT_W-1:0] queue_count;

    iparc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_axis_tvalid),
        .s_ready     (s_axis_tready),
        .s_data      (s_axis_tdata),
        .s_last      (s_axis_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .queue_count (queue_count),
        .burst       (burst)
    );

    iparc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .burst   (burst),
        .count   (queue_count),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_item  (m_item)
    );

    assign m_axis_tdata = m_item.data;
    assign m_axis_tlast = m_item.last;
    assign m_axis_tuser = {m_item.short_header, m_item.not_version_four};

endmodule

`default_nettype wire
